@@ design/ups_pkg.sv @@
// Shared constants, register codes and controller/datapath interface types
// for the Ulam prime spiral walker. No dependencies.
package ups_pkg;

    localparam int SIEVE_SIZE = 2048;
    localparam int ADDR_W     = $clog2(SIEVE_SIZE);
    localparam int SQ_W       = ADDR_W + 1;

    localparam int SIDE_W  = 6;
    localparam int START_W = 8;
    localparam int COORD_W = 10;
    localparam int INDEX_W = 11;
    localparam int CFG_IDX_W = 2;

    // Largest side length whose L*(L-1) cells fit in the bitmap.
    function automatic int max_side();
        int s;
        s = (1 << SIDE_W) - 1;
        while (s > 2 && s * (s - 1) > SIEVE_SIZE)
            s = s - 1;
        return s;
    endfunction

    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(max_side());
    localparam logic [SIDE_W-1:0] SIDE_MIN = SIDE_W'(2);

    localparam logic [SIDE_W-1:0]  RST_SIDE    = SIDE_W'(40);
    localparam logic [START_W-1:0] RST_START_X = START_W'(20);
    localparam logic [START_W-1:0] RST_START_Y = START_W'(12);

    localparam logic [CFG_IDX_W-1:0] REG_SIDE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_build;
        logic fill_step;
        logic probe;
        logic cross_start;
        logic cross_step;
        logic next_n;
        logic emit;
    } ups_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_done;
        logic prime_bit;
        logic cross_done;
        logic sieve_last;
        logic out_valid;
    } ups_status_t;

endpackage

@@ design/ups_bitmap_ram.sv @@
// Single-bit primality bitmap: one write port, one read port with registered data.
// Depends on ups_pkg for depth and address width.
module ups_bitmap_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ups_pkg::ADDR_W-1:0] waddr,
    input  logic                      wdata,
    input  logic                      re,
    input  logic [ups_pkg::ADDR_W-1:0] raddr,
    output logic                      rdata
);

    logic mem [ups_pkg::SIEVE_SIZE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/ups_ctrl.sv @@
// Controller state machine: sequences sieve building and spiral steps.
// Depends on ups_pkg for the command and status types.
module ups_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 restart,
    input  logic                 m_tready,
    output logic                 s_tready,
    input  ups_pkg::ups_status_t status,
    output ups_pkg::ups_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_WALK,
        ST_FILL,
        ST_PROBE,
        ST_CHECK,
        ST_CROSS,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   accept;

    assign s_tready = (state_reg == ST_WALK) && (!status.out_valid || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            ST_WALK:
            begin
                if (accept)
                begin
                    if (restart || !ready_reg)
                    begin
                        cmd.start_build = 1'b1;
                        state_next      = ST_FILL;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_done)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cmd.probe  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.prime_bit)
                begin
                    cmd.cross_start = 1'b1;
                    state_next      = ST_CROSS;
                end
                else
                begin
                    cmd.next_n = 1'b1;
                    state_next = status.sieve_last ? ST_EMIT : ST_PROBE;
                end
            end
            ST_CROSS:
            begin
                cmd.cross_step = 1'b1;
                if (status.cross_done)
                begin
                    cmd.next_n = 1'b1;
                    state_next = status.sieve_last ? ST_EMIT : ST_PROBE;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                ready_next = 1'b1;
                state_next = ST_WALK;
            end
            default:
            begin
                state_next = ST_WALK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WALK;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

@@ design/ups_datapath.sv @@
// Datapath: sieve counters, bitmap, spiral walk registers and output register.
// Depends on ups_pkg and ups_bitmap_ram.
module ups_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ups_pkg::ups_cmd_t                  cmd,
    output ups_pkg::ups_status_t               status,
    input  logic                               m_tready,
    input  logic [ups_pkg::SIDE_W-1:0]         side_length,
    input  logic [ups_pkg::START_W-1:0]        start_x,
    input  logic [ups_pkg::START_W-1:0]        start_y,
    output logic signed [ups_pkg::COORD_W-1:0] cell_x,
    output logic signed [ups_pkg::COORD_W-1:0] cell_y,
    output logic [ups_pkg::INDEX_W-1:0]        cell_index,
    output logic                               is_prime,
    output logic                               last_cell
);

    typedef enum logic [1:0] {
        HEAD_PX,
        HEAD_PY,
        HEAD_NX,
        HEAD_NY
    } heading_t;

    // Sieve counters.
    logic [ups_pkg::ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [ups_pkg::ADDR_W-1:0] n_reg, n_next;
    logic [ups_pkg::SQ_W-1:0]   nsq_reg, nsq_next;
    logic [ups_pkg::SQ_W-1:0]   k_reg, k_next;
    logic [ups_pkg::SQ_W-1:0]   nsq_inc;
    logic [ups_pkg::SQ_W-1:0]   k_sum;

    // Walk state.
    logic [ups_pkg::INDEX_W-1:0] index_reg, index_next;
    logic [ups_pkg::COORD_W-1:0] x_reg, x_next;
    logic [ups_pkg::COORD_W-1:0] y_reg, y_next;
    heading_t                    head_reg, head_next;
    logic [ups_pkg::SIDE_W-1:0]  run_reg, run_next;
    logic                        leg_reg, leg_next;
    logic [ups_pkg::SIDE_W-1:0]  step_reg, step_next;

    // Output register; the prime bit lives in the bitmap read register.
    logic [ups_pkg::COORD_W-1:0] out_x_reg, out_y_reg;
    logic [ups_pkg::INDEX_W-1:0] out_index_reg;
    logic                        out_last_reg;
    logic                        out_valid_reg, out_valid_next;

    logic [ups_pkg::SIDE_W-1:0] side_eff;
    logic [ups_pkg::SIDE_W-1:0] side_m1;
    logic [ups_pkg::SIDE_W:0]   step_inc;
    logic                       walk_last;

    logic                       ram_we;
    logic [ups_pkg::ADDR_W-1:0] ram_waddr;
    logic                       ram_wdata;
    logic                       ram_re;
    logic [ups_pkg::ADDR_W-1:0] ram_raddr;
    logic                       ram_rdata;

    // Effective side length after clamping to what the bitmap can hold.
    always_comb
    begin
        if (side_length < ups_pkg::SIDE_MIN)
        begin
            side_eff = ups_pkg::SIDE_MIN;
        end
        else if (side_length > ups_pkg::SIDE_MAX)
        begin
            side_eff = ups_pkg::SIDE_MAX;
        end
        else
        begin
            side_eff = side_length;
        end
    end

    assign side_m1   = side_eff - ups_pkg::SIDE_W'(1);
    assign step_inc  = {1'b0, step_reg} + (ups_pkg::SIDE_W + 1)'(1);
    assign walk_last = leg_reg && (step_inc >= {1'b0, run_reg}) && (run_reg >= side_m1);

    // (n+1)^2 = n^2 + 2n + 1, kept incrementally.
    assign nsq_inc = nsq_reg + {n_reg, 1'b1};
    assign k_sum   = k_reg + ups_pkg::SQ_W'(n_reg);

    assign status.fill_done  = (fill_addr_reg == ups_pkg::ADDR_W'(ups_pkg::SIEVE_SIZE - 1));
    assign status.prime_bit  = ram_rdata;
    assign status.cross_done = (k_sum >= ups_pkg::SQ_W'(ups_pkg::SIEVE_SIZE));
    assign status.sieve_last = (nsq_inc >= ups_pkg::SQ_W'(ups_pkg::SIEVE_SIZE));
    assign status.out_valid  = out_valid_reg;

    // Bitmap port selection.
    always_comb
    begin
        ram_we    = cmd.fill_step || cmd.cross_step;
        ram_waddr = cmd.fill_step ? fill_addr_reg : k_reg[ups_pkg::ADDR_W-1:0];
        ram_wdata = cmd.fill_step && (fill_addr_reg >= ups_pkg::ADDR_W'(2));
        ram_re    = cmd.probe || cmd.emit;
        ram_raddr = cmd.probe ? n_reg : ups_pkg::ADDR_W'(index_reg);
    end

    ups_bitmap_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sieve counter updates.
    always_comb
    begin
        fill_addr_next = fill_addr_reg;
        n_next         = n_reg;
        nsq_next       = nsq_reg;
        k_next         = k_reg;
        if (cmd.start_build)
        begin
            fill_addr_next = '0;
            n_next         = ups_pkg::ADDR_W'(2);
            nsq_next       = ups_pkg::SQ_W'(4);
        end
        if (cmd.fill_step)
        begin
            fill_addr_next = fill_addr_reg + ups_pkg::ADDR_W'(1);
        end
        if (cmd.cross_start)
        begin
            k_next = nsq_reg;
        end
        if (cmd.cross_step)
        begin
            k_next = k_sum;
        end
        if (cmd.next_n)
        begin
            n_next   = n_reg + ups_pkg::ADDR_W'(1);
            nsq_next = nsq_inc;
        end
    end

    // Walk updates: rewind on build start or after the last cell, else step.
    always_comb
    begin
        index_next = index_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        head_next  = head_reg;
        run_next   = run_reg;
        leg_next   = leg_reg;
        step_next  = step_reg;
        if (cmd.start_build || (cmd.emit && walk_last))
        begin
            index_next = '0;
            x_next     = ups_pkg::COORD_W'(start_x);
            y_next     = ups_pkg::COORD_W'(start_y);
            head_next  = HEAD_PX;
            run_next   = ups_pkg::SIDE_W'(1);
            leg_next   = 1'b0;
            step_next  = '0;
        end
        else if (cmd.emit)
        begin
            case (head_reg)
                HEAD_PX: x_next = x_reg + ups_pkg::COORD_W'(1);
                HEAD_PY: y_next = y_reg + ups_pkg::COORD_W'(1);
                HEAD_NX: x_next = x_reg - ups_pkg::COORD_W'(1);
                HEAD_NY: y_next = y_reg - ups_pkg::COORD_W'(1);
                default: x_next = x_reg;
            endcase
            index_next = index_reg + ups_pkg::INDEX_W'(1);
            if (step_inc >= {1'b0, run_reg})
            begin
                step_next = '0;
                head_next = heading_t'(head_reg + 2'd1);
                leg_next  = !leg_reg;
                if (leg_reg)
                begin
                    run_next = run_reg + ups_pkg::SIDE_W'(1);
                end
            end
            else
            begin
                step_next = step_inc[ups_pkg::SIDE_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            index_reg     <= '0;
            x_reg         <= ups_pkg::COORD_W'(ups_pkg::RST_START_X);
            y_reg         <= ups_pkg::COORD_W'(ups_pkg::RST_START_Y);
            head_reg      <= HEAD_PX;
            run_reg       <= ups_pkg::SIDE_W'(1);
            leg_reg       <= 1'b0;
            step_reg      <= '0;
            fill_addr_reg <= '0;
            n_reg         <= ups_pkg::ADDR_W'(2);
            nsq_reg       <= ups_pkg::SQ_W'(4);
            k_reg         <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            index_reg     <= index_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            head_reg      <= head_next;
            run_reg       <= run_next;
            leg_reg       <= leg_next;
            step_reg      <= step_next;
            fill_addr_reg <= fill_addr_next;
            n_reg         <= n_next;
            nsq_reg       <= nsq_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_index_reg <= index_reg;
            out_last_reg  <= walk_last;
        end
    end

    assign cell_x     = out_x_reg;
    assign cell_y     = out_y_reg;
    assign cell_index = out_index_reg;
    assign is_prime   = ram_rdata;
    assign last_cell  = out_last_reg;

endmodule

@@ design/ulam_prime_spiral_walker_top.sv @@
// Top level of the Ulam prime spiral walker: configuration registers and the
// controller/datapath pair. Depends on ups_pkg, ups_ctrl and ups_datapath.
//
// Usage:
//   Each transfer on the input stream (s_tvalid/s_tready/s_tdata) asks for one
//   spiral cell; s_tdata bit 0 is the restart flag. Each request yields exactly
//   one transfer on the output stream (m_tvalid/m_tready/m_tdata/m_tlast) that
//   carries the cell's coordinates, its index along the spiral, whether that
//   index is prime, and m_tlast on the final cell of the spiral.
//   On a normal step the result is registered at the edge that completes the
//   input transfer and is offered from the next cycle on, and a new request can
//   be taken every cycle while the output side takes results. A request with
//   restart set, and the first request after reset, rebuild the prime bitmap
//   first. The build is bounded by the bitmap's single write port: it presets
//   every entry of the 2048-entry bitmap, probes each candidate factor up to the
//   square root of the size, and crosses out the multiples of each prime found.
//   The walk is rewound to the configured start point and cell zero follows the
//   build. Reset clears the walk and marks the bitmap as unbuilt; the
//   configuration registers return to side length 40 and start point (20, 12).
//   While the receiver stalls, the result is held and s_tready stays low, so no
//   request is lost. Configuration is written over the APB port at byte
//   addresses 0 (side_length), 4 (start_x) and 8 (start_y); the user must write
//   it only while idle, as the block does not enforce this.
module ulam_prime_spiral_walker_top (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [9:0] cell_x, [19:10] cell_y, [30:20] cell_index,
                                   // [31] is_prime
    output logic        m_tlast,   // last_cell
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ups_pkg::SIDE_W-1:0]  side_reg;
    logic [ups_pkg::START_W-1:0] start_x_reg;
    logic [ups_pkg::START_W-1:0] start_y_reg;
    logic [ups_pkg::CFG_IDX_W-1:0] reg_index;
    logic                        cfg_write;

    ups_pkg::ups_cmd_t    cmd;
    ups_pkg::ups_status_t status;

    logic signed [ups_pkg::COORD_W-1:0] cell_x;
    logic signed [ups_pkg::COORD_W-1:0] cell_y;
    logic [ups_pkg::INDEX_W-1:0]        cell_index;
    logic                               is_prime;
    logic                               last_cell;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes land on the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg    <= ups_pkg::RST_SIDE;
            start_x_reg <= ups_pkg::RST_START_X;
            start_y_reg <= ups_pkg::RST_START_Y;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                ups_pkg::REG_SIDE:    side_reg    <= pwdata[ups_pkg::SIDE_W-1:0];
                ups_pkg::REG_START_X: start_x_reg <= pwdata[ups_pkg::START_W-1:0];
                ups_pkg::REG_START_Y: start_y_reg <= pwdata[ups_pkg::START_W-1:0];
                default:              side_reg    <= side_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            ups_pkg::REG_SIDE:    prdata = 32'(side_reg);
            ups_pkg::REG_START_X: prdata = 32'(start_x_reg);
            ups_pkg::REG_START_Y: prdata = 32'(start_y_reg);
            default:              prdata = '0;
        endcase
    end

    ups_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .restart  (s_tdata[0]),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ups_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .side_length (side_reg),
        .start_x     (start_x_reg),
        .start_y     (start_y_reg),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_index  (cell_index),
        .is_prime    (is_prime),
        .last_cell   (last_cell)
    );

    // Fields packed from the lowest bit up.
    assign m_tvalid = status.out_valid;
    assign m_tdata  = {is_prime, cell_index, cell_y, cell_x};
    assign m_tlast  = last_cell;

endmodule

@@ design/ups_checker.sv @@
// Port-level checker for the Ulam prime spiral walker, bound to the top level.
// Depends only on the top level's ports.
module ups_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result blocks new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while a result is stalled");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // A restart drains the output and starts a build with requests blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[0] |=> !m_tvalid && !s_tready)
        else $error("restart did not start a bitmap build");

    // Cell zero never ends the spiral.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[30:20] == 11'd0) |-> !m_tlast)
        else $error("cell zero marked last");

    // Indices zero and one are never prime.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[30:20] == 11'd0 || m_tdata[30:20] == 11'd1) |-> !m_tdata[31])
        else $error("index below two reported prime");

endmodule

bind ulam_prime_spiral_walker_top ups_checker u_ups_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for ulam_prime_spiral_walker_top: checks spiral
// cells against a predictor. Uses ups_pkg for widths, sizes and register codes.
module tb_top;

    // A request that sits unanswered for this many cycles means the block hung.
    // It covers a bitmap build several times over, plus the long receiver hold.
    localparam int QUIET_LIMIT = 60000;
    // Length of the deliberate receiver hold that backs up the input stream.
    localparam int LONG_HOLD = 500;

    // One output cell, in the order the fields appear in m_tdata plus m_tlast.
    typedef struct packed {
        logic [ups_pkg::COORD_W-1:0] x;
        logic [ups_pkg::COORD_W-1:0] y;
        logic [ups_pkg::INDEX_W-1:0] idx;
        logic                        prime;
        logic                        last;
    } cell_t;

    // Headings of the spiral, turning in this order after each run.
    typedef enum logic [1:0] {
        DIR_PX = 2'd0,
        DIR_PY = 2'd1,
        DIR_NX = 2'd2,
        DIR_NY = 2'd3
    } dir_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [9:0] cell_x, [19:10] cell_y, [30:20] cell_index,
                                   // [31] is_prime
    logic        m_tlast;          // last_cell
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    ulam_prime_spiral_walker_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // Pending restart flags, one per request still to be sent.
    bit    step_q[$];
    // Cells the block owes us, oldest first.
    cell_t cells_due[$];

    // Predictor state: the shadow registers and the shadow walk.
    logic [ups_pkg::SIDE_W-1:0]  cfg_side = ups_pkg::RST_SIDE;
    logic [ups_pkg::START_W-1:0] cfg_sx = ups_pkg::RST_START_X;
    logic [ups_pkg::START_W-1:0] cfg_sy = ups_pkg::RST_START_Y;
    bit                          prime_map [ups_pkg::SIEVE_SIZE];
    bit                          map_built = 1'b0;
    int unsigned                 walk_idx;
    logic [ups_pkg::COORD_W-1:0] pos_x;
    logic [ups_pkg::COORD_W-1:0] pos_y;
    dir_t                        dir;
    int unsigned                 run_len;
    bit                          second_leg;
    int unsigned                 leg_step;

    // Bookkeeping.
    int  mismatches = 0;
    int  n_requests = 0;
    int  n_cells = 0;
    int  n_builds = 0;
    int  n_wraps = 0;
    int  n_settings = 0;
    bit  sender_idles = 1'b0;
    bit  receiver_idles = 1'b0;
    int  stall_asked = 0;
    int  stall_served = 0;
    int  send_gap = 0;
    int  ready_gap = 0;
    int  hold_left = 0;
    int  quiet = 0;
    cell_t got_cell;
    cell_t want_cell;

    // Most gaps are short, a few are much longer.
    function automatic int draw_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 70);
    endfunction

    // Side length as the block uses it: at least 2, and small enough that
    // L*(L-1) cells fit in the bitmap.
    function automatic int unsigned usable_side();
        int unsigned s;
        s = cfg_side;
        if (s < 2)
            s = 2;
        while (s > 2 && s * (s - 1) > ups_pkg::SIEVE_SIZE)
            s--;
        return s;
    endfunction

    task automatic build_prime_map();
        for (int n = 0; n < ups_pkg::SIEVE_SIZE; n++)
            prime_map[n] = (n >= 2);
        for (int n = 2; n * n < ups_pkg::SIEVE_SIZE; n++)
            if (prime_map[n])
                for (int k = n * n; k < ups_pkg::SIEVE_SIZE; k += n)
                    prime_map[k] = 1'b0;
        map_built = 1'b1;
        n_builds++;
    endtask

    // Back to cell zero at whatever start point is configured right now.
    task automatic rewind_spiral();
        walk_idx   = 0;
        pos_x      = ups_pkg::COORD_W'(cfg_sx);
        pos_y      = ups_pkg::COORD_W'(cfg_sy);
        dir        = DIR_PX;
        run_len    = 1;
        second_leg = 1'b0;
        leg_step   = 0;
    endtask

    // Work out the cell that one accepted request produces and move the
    // shadow walk on to the next cell.
    task automatic spiral_step(input bit restart);
        cell_t       c;
        int unsigned side;
        bit          at_end;
        if (restart || !map_built)
        begin
            build_prime_map();
            rewind_spiral();
        end
        side   = usable_side();
        // The spiral ends on the second leg of a run of length L-1 or longer;
        // longer runs happen when side_length was lowered mid-walk.
        at_end = second_leg && (leg_step + 1 >= run_len) && (run_len >= side - 1);
        c.x     = pos_x;
        c.y     = pos_y;
        c.idx   = walk_idx[ups_pkg::INDEX_W-1:0];
        c.prime = (walk_idx < ups_pkg::SIEVE_SIZE) ? prime_map[walk_idx] : 1'b0;
        c.last  = at_end;
        cells_due.push_back(c);
        if (at_end)
        begin
            n_wraps++;
            rewind_spiral();
        end
        else
        begin
            case (dir)
                DIR_PX: pos_x = pos_x + ups_pkg::COORD_W'(1);
                DIR_PY: pos_y = pos_y + ups_pkg::COORD_W'(1);
                DIR_NX: pos_x = pos_x - ups_pkg::COORD_W'(1);
                default: pos_y = pos_y - ups_pkg::COORD_W'(1);
            endcase
            walk_idx++;
            leg_step++;
            if (leg_step >= run_len)
            begin
                leg_step = 0;
                dir = dir_t'(2'(dir + 2'd1));
                if (!second_leg)
                    second_leg = 1'b1;
                else
                begin
                    second_leg = 1'b0;
                    run_len++;
                end
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Driver: sends the queued requests, with random gaps between them, and
    // feeds every accepted transfer to the predictor. A request that is not
    // taken stays on the bus unchanged.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                n_requests++;
                spiral_step(s_tdata[0]);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (step_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, step_q.pop_front()};
                    send_gap <= draw_gap(sender_idles);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: takes cells off the output stream and checks each field against
    // the oldest expected cell. Ready is dropped at random, and for one long
    // hold once a cell is waiting after the stimulus asks for it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            ready_gap <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_cells++;
                got_cell = {m_tdata[9:0], m_tdata[19:10], m_tdata[30:20], m_tdata[31],
                            m_tlast};
                if (cells_due.size() == 0)
                    flag_mismatch("cell with nothing expected", m_tdata, 32'd0);
                else
                begin
                    want_cell = cells_due.pop_front();
                    if (got_cell.x !== want_cell.x)
                        flag_mismatch("cell_x", 32'(got_cell.x), 32'(want_cell.x));
                    if (got_cell.y !== want_cell.y)
                        flag_mismatch("cell_y", 32'(got_cell.y), 32'(want_cell.y));
                    if (got_cell.idx !== want_cell.idx)
                        flag_mismatch("cell_index", 32'(got_cell.idx), 32'(want_cell.idx));
                    if (got_cell.prime !== want_cell.prime)
                        flag_mismatch("is_prime", 32'(got_cell.prime), 32'(want_cell.prime));
                    if (got_cell.last !== want_cell.last)
                        flag_mismatch("last_cell", 32'(got_cell.last), 32'(want_cell.last));
                end
            end
            if (stall_served != stall_asked && m_tvalid)
            begin
                stall_served <= stall_asked;
                hold_left    <= LONG_HOLD;
                m_tready     <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap <= ready_gap - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    ready_gap <= draw_gap(receiver_idles);
            end
        end
    end

    // Watchdog: any cycle with a transfer on either stream or a register
    // write resets the count; a long silence ends the run as a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (psel && penable && pwrite && pready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, quiet);
                $display("[ulam_prime_spiral_walker_top] ERROR");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // Register write: a setup phase, then an access phase; the register takes
    // the value at the edge that closes the access phase.
    task automatic reg_write(input logic [ups_pkg::CFG_IDX_W-1:0] code,
                             input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (code)
            ups_pkg::REG_SIDE:    cfg_side = value[ups_pkg::SIDE_W-1:0];
            ups_pkg::REG_START_X: cfg_sx = value[ups_pkg::START_W-1:0];
            ups_pkg::REG_START_Y: cfg_sy = value[ups_pkg::START_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every queued request has gone out and every cell has come
    // back, then leave a margin before touching the registers.
    task automatic settle();
        while (step_q.size() != 0 || s_tvalid || cells_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // New setting for the walk. With noise set, the unused upper bits of the
    // write data are random; the registers must ignore them.
    task automatic set_walk(input int side, input int sx, input int sy, input bit noise);
        logic [31:0] junk;
        settle();
        junk = noise ? $urandom() : 32'd0;
        reg_write(ups_pkg::REG_SIDE,
                  {junk[31:ups_pkg::SIDE_W], ups_pkg::SIDE_W'(side)});
        reg_write(ups_pkg::REG_START_X,
                  {junk[31:ups_pkg::START_W], ups_pkg::START_W'(sx)});
        reg_write(ups_pkg::REG_START_Y,
                  {junk[31:ups_pkg::START_W], ups_pkg::START_W'(sy)});
        n_settings++;
    endtask

    task automatic queue_steps(input int count, input int restart_pct);
        for (int i = 0; i < count; i++)
            step_q.push_back($urandom_range(0, 99) < restart_pct);
    endtask

    function automatic int pick_start();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        else if (r == 1)
            return 255;
        else
            return $urandom_range(0, 255);
    endfunction

    initial
    begin
        int side;
        rewind_spiral();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The very first request has restart clear, so the
        // build must come from the first-request rule; a restart in the middle
        // of a walk follows.
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        step_q = '{0, 0, 0, 1, 0, 0};
        // A side length below the minimum acts as 2: a two-cell spiral that
        // wraps on every second request.
        set_walk(0, 0, 0, 1'b0);
        step_q = '{0, 0, 0, 0, 0};
        // Side 3 from the origin walks into negative x before wrapping.
        set_walk(3, 0, 0, 1'b0);
        step_q = '{0, 0, 0, 0, 0, 0, 0};
        // An oversized side length is clamped; the new start point only
        // shows once the walk is rewound, here by a restart.
        set_walk(63, 255, 255, 1'b0);
        step_q = '{1, 0, 0, 0, 0};

        // Random phases over a range of settings, the extremes included.
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: side = 2;
                1: side = 1;
                2: side = 45;
                3: side = $urandom_range(46, 63);
                4: side = $urandom_range(3, 12);
                default: side = $urandom_range(4, 9);
            endcase
            set_walk(side, pick_start(), pick_start(), p[0]);
            sender_idles   = (p != 4) && $urandom_range(0, 1);
            receiver_idles = (p != 4) && $urandom_range(0, 1);
            queue_steps(6, 15);

            // Once, in the middle: a full walk of a side-33 spiral, long
            // enough for cell indexes past 1023 and ending on its last cell.
            // The sender keeps pushing while the receiver holds off for a
            // long stretch, so the block must stall its input.
            if (p == 3)
            begin
                set_walk(33, 255, 0, 1'b0);
                sender_idles   = 1'b0;
                receiver_idles = 1'b1;
                step_q.push_back(1'b1);
                queue_steps(1055, 0);
                stall_asked++;
            end
        end

        settle();
        if (cells_due.size() != 0)
            flag_mismatch("cells never delivered", 32'(cells_due.size()), 32'd0);
        $display("Run covered %0d requests and %0d checked cells over %0d settings,",
                 n_requests, n_cells, n_settings);
        $display("with %0d bitmap builds, %0d spiral wraps and %0d mismatches.",
                 n_builds, n_wraps, mismatches);
        if (mismatches == 0)
            $display("[ulam_prime_spiral_walker_top] OK");
        else
            $display("[ulam_prime_spiral_walker_top] ERROR");
        $finish;
    end

endmodule
